// ===== sv/linked_queue_with_free_list_assert.svh =====
// assertion macros for the linked queue checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef LINKED_QUEUE_WITH_FREE_LIST_ASSERT_SVH
`define LINKED_QUEUE_WITH_FREE_LIST_ASSERT_SVH

// same-cycle implication, reset masks the check
`define LQFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define LQFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lqfl_pkg.sv =====
// shared constants, types and helpers for the linked queue block
// no dependencies
`default_nettype none

package lqfl_pkg;

    localparam int NODE_COUNT = 16;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int IDX_W      = $clog2(NODE_COUNT + 1);

    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_COUNT);

    localparam int ID_W       = 32;
    localparam int NAME_W     = 64;
    localparam int NAME_HI_W  = 32;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_PAD_W  = 4;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [NAME_HI_W-1:0] name_high;
        logic [NAME_W-1:0]    name_mid;
        logic [NAME_W-1:0]    name_low;
        logic signed [ID_W-1:0] id;
    } record_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    function automatic logic is_node(logic [IDX_W-1:0] v);
        return v < IDX_W'(NODE_COUNT);
    endfunction

    function automatic logic [IDX_W-1:0] clean_link(logic [IDX_W-1:0] v);
        return is_node(v) ? v : NIL;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lqfl_ctrl.sv =====
// handshake controller for the linked queue: issue and commit phases
// depends on lqfl_pkg
`default_nettype none

module lqfl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output lqfl_pkg::ctrl_cmd_t     cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign s_tready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || m_tready;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == S_EXEC) && out_free;
    assign m_tvalid   = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lqfl_datapath.sv =====
// node store, free list and queue pointers with the result register
// depends on lqfl_pkg
`default_nettype none

module lqfl_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire lqfl_pkg::ctrl_cmd_t                cmd,
    input  wire logic                               in_op,
    input  wire lqfl_pkg::record_t                  in_rec,
    output logic [lqfl_pkg::STATUS_W-1:0]           out_status,
    output logic [lqfl_pkg::SLOT_W-1:0]             out_slot,
    output lqfl_pkg::record_t                       out_rec
);

    localparam int IDX_W  = lqfl_pkg::IDX_W;
    localparam int ADDR_W = lqfl_pkg::ADDR_W;
    localparam int SLOT_W = lqfl_pkg::SLOT_W;

    // memories
    logic [IDX_W-1:0]  link_mem [lqfl_pkg::NODE_COUNT];
    lqfl_pkg::record_t rec_mem  [lqfl_pkg::NODE_COUNT];

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] queue_head_reg, queue_head_next;
    logic [IDX_W-1:0] queue_tail_reg, queue_tail_next;
    // nodes below this index were never handed out, their links are implied
    logic [IDX_W-1:0] fresh_reg, fresh_next;
    logic             op_reg;

    logic [IDX_W-1:0]  link_rd_reg;
    lqfl_pkg::record_t rec_rd_reg;

    logic [IDX_W-1:0]  rd_node;
    logic [ADDR_W-1:0] rd_addr;
    logic              rec_we;

    logic [IDX_W-1:0]  node;
    logic              node_ok;
    logic [IDX_W-1:0]  link_val;
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [IDX_W-1:0]  link_wdata;

    logic [lqfl_pkg::STATUS_W-1:0] status_c;
    logic [SLOT_W-1:0]             slot_c;
    lqfl_pkg::record_t             rec_c;

    logic [lqfl_pkg::STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]             out_slot_reg;
    lqfl_pkg::record_t             out_rec_reg;

    // issue phase: one read address serves both memories
    assign rd_node = (in_op == lqfl_pkg::OP_DEQ) ? queue_head_reg : free_head_reg;
    assign rd_addr = rd_node[ADDR_W-1:0];
    assign rec_we  = cmd.accept && (in_op == lqfl_pkg::OP_ENQ)
                     && lqfl_pkg::is_node(free_head_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            link_rd_reg <= link_mem[rd_addr];
            rec_rd_reg  <= rec_mem[rd_addr];
            op_reg      <= in_op;
        end
        if (rec_we) begin
            rec_mem[rd_addr] <= in_rec;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    // commit phase
    always_comb begin
        node    = (op_reg == lqfl_pkg::OP_DEQ) ? queue_head_reg : free_head_reg;
        node_ok = lqfl_pkg::is_node(node);

        if (node < fresh_reg) begin
            link_val = (node == '0) ? lqfl_pkg::NIL : node - IDX_W'(1);
        end else begin
            link_val = lqfl_pkg::clean_link(link_rd_reg);
        end

        free_head_next  = free_head_reg;
        queue_head_next = queue_head_reg;
        queue_tail_next = queue_tail_reg;
        fresh_next      = fresh_reg;
        link_we         = 1'b0;
        link_waddr      = queue_tail_reg[ADDR_W-1:0];
        link_wdata      = node;
        status_c        = lqfl_pkg::ST_DONE;
        slot_c          = '0;
        rec_c           = '0;

        if (op_reg == lqfl_pkg::OP_ENQ) begin
            if (!node_ok) begin
                status_c = lqfl_pkg::ST_FULL;
            end else begin
                slot_c         = SLOT_W'(node);
                free_head_next = link_val;
                if (node < fresh_reg) begin
                    fresh_next = node;
                end
                // the tail link is only read after a later enqueue overwrites it
                if (lqfl_pkg::is_node(queue_tail_reg)) begin
                    link_we = cmd.commit;
                end else begin
                    queue_head_next = node;
                end
                queue_tail_next = node;
            end
        end else begin
            if (!node_ok) begin
                status_c = lqfl_pkg::ST_EMPTY;
            end else begin
                slot_c = SLOT_W'(node);
                rec_c  = rec_rd_reg;
                // last node out empties the queue
                if (node == queue_tail_reg) begin
                    queue_head_next = lqfl_pkg::NIL;
                    queue_tail_next = lqfl_pkg::NIL;
                end else begin
                    queue_head_next = link_val;
                end
                link_we        = cmd.commit;
                link_waddr     = node[ADDR_W-1:0];
                link_wdata     = lqfl_pkg::clean_link(free_head_reg);
                free_head_next = node;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= IDX_W'(lqfl_pkg::NODE_COUNT - 1);
            queue_head_reg <= lqfl_pkg::NIL;
            queue_tail_reg <= lqfl_pkg::NIL;
            fresh_reg      <= IDX_W'(lqfl_pkg::NODE_COUNT);
        end else if (cmd.commit) begin
            free_head_reg  <= free_head_next;
            queue_head_reg <= queue_head_next;
            queue_tail_reg <= queue_tail_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= status_c;
            out_slot_reg   <= slot_c;
            out_rec_reg    <= rec_c;
        end
    end

    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_rec    = out_rec_reg;

endmodule

`default_nettype wire

// ===== sv/linked_queue_with_free_list.sv =====
// top level of the linked queue with free list
// depends on lqfl_pkg, lqfl_ctrl and lqfl_datapath
//
// usage
//   s_ channel carries commands: s_tuser is the operation (enqueue or dequeue),
//   s_tdata the record to enqueue (ignored on dequeue)
//   m_ channel returns exactly one item per command: m_tuser is the status
//   (done, store full, queue empty), m_tdata the slot and the dequeued record
//   the link store read that moves the free or queue head is registered, so
//   each command has an issue phase and a commit phase; a new command is
//   taken only after the current one commits, and s_tready is low in the
//   commit phase; the next command is taken while a finished result waits
//   in the output register; if the receiver stalls, the commit phase holds
//   until the output register frees, and s_tready stays low meanwhile
//   reset: queue empty, all nodes free, handed out from the highest index
//   down; no clearing pass, untouched nodes keep implied links through a
//   fill count, so the block is ready as soon as reset is released
`default_nettype none

module linked_queue_with_free_list (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // student_id, name_bytes_low, name_bytes_mid, name_bytes_high
    input  wire logic [lqfl_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // slot, out_id, out_name_low, out_name_mid, out_name_high, zero pad
    output logic [lqfl_pkg::OUT_DATA_W-1:0]         m_tdata,
    // status
    output logic [lqfl_pkg::STATUS_W-1:0]           m_tuser
);

    lqfl_pkg::ctrl_cmd_t cmd;
    lqfl_pkg::record_t   in_rec;
    lqfl_pkg::record_t   out_rec;
    logic [lqfl_pkg::SLOT_W-1:0] out_slot;

    // record layout matches the input packing, id in the low bits
    assign in_rec = lqfl_pkg::record_t'(s_tdata);

    lqfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lqfl_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_op      (s_tuser[0]),
        .in_rec     (in_rec),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_rec    (out_rec)
    );

    // slot in the low nibble, then the record, zero pad on top
    assign m_tdata = {{lqfl_pkg::OUT_PAD_W{1'b0}}, out_rec, out_slot};

endmodule

`default_nettype wire

// ===== sv/lqfl_checker.sv =====
// port-level checks for the linked queue, bound to the top level
// depends on linked_queue_with_free_list_assert.svh and lqfl_pkg
`default_nettype none

`include "linked_queue_with_free_list_assert.svh"

module lqfl_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [lqfl_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic [lqfl_pkg::STATUS_W-1:0]      m_tuser
);

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    // one command in flight: no second accept right after one
    `LQFL_ASSERT_NEXT(a_one_in_flight, in_acc, !s_tready, "input taken while busy")

    // a free output at accept means the commit phase does not stall, so the result shows
    `LQFL_ASSERT_NEXT(a_result_due, in_acc && (!m_tvalid || m_tready), ##1 m_tvalid,
        "result missing after accept")

    // busy with nothing pending downstream is idle again in the next cycle
    `LQFL_ASSERT_NEXT(a_no_hang, !s_tready && !m_tvalid, s_tready, "commit stuck")

    // a stalled result holds
    `LQFL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind linked_queue_with_free_list lqfl_checker u_lqfl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
